>>> hw/rtl/i2c_master_byte_engine_assert.svh
// ----------------------------------------------------------------------------
// i2c master byte engine assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled in reset
`define MBE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c master byte engine assertion failed");

// next-cycle implication, disabled in reset
`define MBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c master byte engine assertion failed");

`else

`define MBE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define MBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/i2c_mbe_pkg.sv
// ----------------------------------------------------------------------------
// i2c master byte engine package
// shared types, codes and reset values
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_mbe_pkg;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
    localparam logic [4:0]  ACK_WAIT_RST    = 5'd20;
    localparam logic        ACK_CHECK_RST   = 1'b1;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CHECK   = 2'd2;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NACK    = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_HELD = 4'd1,
        PH_S0   = 4'd2,
        PH_S1   = 4'd3,
        PH_S2   = 4'd4,
        PH_S3   = 4'd5,
        PH_BL   = 4'd6,
        PH_BH   = 4'd7,
        PH_AL   = 4'd8,
        PH_AH   = 4'd9,
        PH_P0   = 4'd10,
        PH_P1   = 4'd11
    } t_phase;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [4:0]  ack_wait_limit;
        logic        ack_check;
    } t_cfg;

    // classified request as it sits in the queue
    typedef struct packed {
        t_kind       kind;
        logic [6:0]  dev_addr;
        logic        read_dir;
        logic [7:0]  wr_byte;
        logic        last_byte;
        logic        sda_in;
    } t_item;

    // queue handshake toward the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

endpackage

`default_nettype wire

>>> hw/rtl/i2c_mbe_req_if.sv
// ----------------------------------------------------------------------------
// i2c master byte engine request channel
// valid/ready channel carrying one command or tick request
// ----------------------------------------------------------------------------
`default_nettype none

interface i2c_mbe_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic       read_dir;
    logic [7:0] wr_byte;
    logic       last_byte;
    logic       sda_in;

    modport source (
        output valid, req_type, dev_addr, read_dir, wr_byte, last_byte, sda_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, dev_addr, read_dir, wr_byte, last_byte, sda_in,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/i2c_mbe_res_if.sv
// ----------------------------------------------------------------------------
// i2c master byte engine result channel
// valid/ready channel carrying one bus result per request
// ----------------------------------------------------------------------------
`default_nettype none

interface i2c_mbe_res_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] rd_byte;
    logic [1:0] status;

    modport source (
        output valid, scl, sda_drive_low, busy_res, done_res, ack_ok, rd_byte, status,
        input  ready
    );
    modport sink (
        input  valid, scl, sda_drive_low, busy_res, done_res, ack_ok, rd_byte, status,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/i2c_mbe_front.sv
// ----------------------------------------------------------------------------
// i2c master byte engine front end
// accepts requests, decodes the request kind, two-entry queue to the back end
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mbe_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    i2c_mbe_req_if.sink          i_req,
    output i2c_mbe_pkg::t_q_out  o_q,
    input  wire                  i_q_pop
);

    i2c_mbe_pkg::t_item r_mem [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;

    i2c_mbe_pkg::t_item w_item;
    logic               w_push;
    logic               w_pop;

    always_comb begin
        w_item.kind      = i2c_mbe_pkg::t_kind'(i_req.req_type);
        w_item.dev_addr  = i_req.dev_addr;
        w_item.read_dir  = i_req.read_dir;
        w_item.wr_byte   = i_req.wr_byte;
        w_item.last_byte = i_req.last_byte;
        w_item.sda_in    = i_req.sda_in;
    end

    assign i_req.ready = (r_count != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_q_pop && (r_count != 2'd0);

    assign o_q.valid = (r_count != 2'd0);
    assign o_q.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2c_mbe_back.sv
// ----------------------------------------------------------------------------
// i2c master byte engine back end
// bus phase sequencer, one queued request per cycle while results are taken, registered result
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_mbe_back (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire i2c_mbe_pkg::t_cfg    i_cfg,
    input  wire i2c_mbe_pkg::t_q_out  i_q,
    output logic                      o_q_pop,
    i2c_mbe_res_if.source             o_res
);

    i2c_mbe_pkg::t_phase r_phase, n_phase;
    logic [3:0]          r_bit, n_bit;
    logic [7:0]          r_shift, n_shift;
    logic [15:0]         r_tick, n_tick;
    logic [4:0]          r_wait, n_wait;
    logic                r_stop, n_stop;
    logic [7:0]          r_rdres, n_rdres;
    logic                r_reading, n_reading;
    logic                r_ackf, n_ackf;
    logic                r_nackf, n_nackf;

    logic                r_out_valid;
    logic                r_scl, n_scl;
    logic                r_drv, n_drv;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic                r_ack, n_ack;
    i2c_mbe_pkg::t_status r_status, n_status;

    logic                w_busy;
    logic [15:0]         w_hp;
    logic [4:0]          w_lim;
    logic                w_end_byte;
    logic                w_end_acked;

    assign o_q_pop = i_q.valid && (!r_out_valid || o_res.ready);

    assign w_busy = !(r_phase inside {i2c_mbe_pkg::PH_IDLE, i2c_mbe_pkg::PH_HELD});
    assign w_hp   = (i_cfg.half_period_ticks == 16'd0) ? 16'd1 : i_cfg.half_period_ticks;
    assign w_lim  = (i_cfg.ack_wait_limit == 5'd0) ? 5'd1 : i_cfg.ack_wait_limit;

    // state update for one request
    always_comb begin
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_wait      = r_wait;
        n_stop      = r_stop;
        n_rdres     = r_rdres;
        n_reading   = r_reading;
        n_ackf      = r_ackf;
        n_nackf     = r_nackf;
        n_done      = 1'b0;
        n_ack       = 1'b0;
        n_status    = i2c_mbe_pkg::ST_OK;
        w_end_byte  = 1'b0;
        w_end_acked = 1'b0;

        if (i_q.item.kind != i2c_mbe_pkg::KIND_TICK) begin
            if (w_busy || (i_q.item.kind != i2c_mbe_pkg::KIND_START &&
                           r_phase == i2c_mbe_pkg::PH_IDLE)) begin
                n_status = i2c_mbe_pkg::ST_REFUSED;
            end else begin
                n_stop  = i_q.item.last_byte;
                n_nackf = 1'b0;
                n_ackf  = 1'b0;
                n_tick  = 16'd0;
                n_bit   = 4'd0;
                n_wait  = 5'd0;
                if (i_q.item.kind == i2c_mbe_pkg::KIND_START) begin
                    n_shift   = {i_q.item.dev_addr, i_q.item.read_dir};
                    n_reading = 1'b0;
                    n_phase   = i2c_mbe_pkg::PH_S0;
                end else begin
                    n_reading = (i_q.item.kind == i2c_mbe_pkg::KIND_READ);
                    n_shift   = n_reading ? 8'd0 : i_q.item.wr_byte;
                    n_phase   = i2c_mbe_pkg::PH_BL;
                end
            end
        end else if (w_busy) begin
            n_tick = r_tick + 16'd1;
            if (n_tick >= w_hp) begin
                n_tick = 16'd0;
                case (r_phase)
                    i2c_mbe_pkg::PH_S0: n_phase = i2c_mbe_pkg::PH_S1;
                    i2c_mbe_pkg::PH_S1: n_phase = i2c_mbe_pkg::PH_S2;
                    i2c_mbe_pkg::PH_S2: n_phase = i2c_mbe_pkg::PH_S3;
                    i2c_mbe_pkg::PH_S3: begin
                        n_phase = i2c_mbe_pkg::PH_BL;
                        n_bit   = 4'd0;
                    end
                    i2c_mbe_pkg::PH_BL: n_phase = i2c_mbe_pkg::PH_BH;
                    i2c_mbe_pkg::PH_BH: begin
                        // msb-first shift, sda sampled only when reading
                        n_shift = {r_shift[6:0], r_reading & i_q.item.sda_in};
                        n_bit   = r_bit + 4'd1;
                        if (n_bit >= 4'd8) begin
                            if (r_reading) begin
                                n_rdres = n_shift;
                            end
                            n_wait  = 5'd0;
                            n_phase = i2c_mbe_pkg::PH_AL;
                        end else begin
                            n_phase = i2c_mbe_pkg::PH_BL;
                        end
                    end
                    i2c_mbe_pkg::PH_AL: n_phase = i2c_mbe_pkg::PH_AH;
                    i2c_mbe_pkg::PH_AH: begin
                        if (r_reading) begin
                            w_end_byte  = 1'b1;
                            w_end_acked = !r_stop;
                        end else if (!i_cfg.ack_check || !i_q.item.sda_in) begin
                            w_end_byte  = 1'b1;
                            w_end_acked = 1'b1;
                        end else begin
                            n_wait = r_wait + 5'd1;
                            if (n_wait >= w_lim) begin
                                n_ackf  = 1'b0;
                                n_nackf = 1'b1;
                                n_phase = i2c_mbe_pkg::PH_P0;
                            end
                        end
                    end
                    i2c_mbe_pkg::PH_P0: n_phase = i2c_mbe_pkg::PH_P1;
                    i2c_mbe_pkg::PH_P1: begin
                        n_phase  = i2c_mbe_pkg::PH_IDLE;
                        n_done   = 1'b1;
                        n_ack    = r_ackf;
                        n_status = r_nackf ? i2c_mbe_pkg::ST_NACK : i2c_mbe_pkg::ST_OK;
                    end
                    default: n_phase = r_phase;
                endcase

                // byte finished: stop if marked last, else hold the bus
                if (w_end_byte) begin
                    n_ackf = w_end_acked;
                    if (r_stop) begin
                        n_phase = i2c_mbe_pkg::PH_P0;
                    end else begin
                        n_phase  = i2c_mbe_pkg::PH_HELD;
                        n_done   = 1'b1;
                        n_ack    = w_end_acked;
                        n_status = i2c_mbe_pkg::ST_OK;
                    end
                end
            end
        end
    end

    // line levels from the new phase
    always_comb begin
        n_busy = !(n_phase inside {i2c_mbe_pkg::PH_IDLE, i2c_mbe_pkg::PH_HELD});
        case (n_phase)
            i2c_mbe_pkg::PH_IDLE: begin n_scl = 1'b1; n_drv = 1'b0; end
            i2c_mbe_pkg::PH_HELD: begin n_scl = 1'b0; n_drv = 1'b0; end
            i2c_mbe_pkg::PH_S0:   begin n_scl = 1'b0; n_drv = 1'b0; end
            i2c_mbe_pkg::PH_S1:   begin n_scl = 1'b1; n_drv = 1'b0; end
            i2c_mbe_pkg::PH_S2:   begin n_scl = 1'b1; n_drv = 1'b1; end
            i2c_mbe_pkg::PH_S3:   begin n_scl = 1'b0; n_drv = 1'b1; end
            i2c_mbe_pkg::PH_BL,
            i2c_mbe_pkg::PH_BH: begin
                n_scl = (n_phase == i2c_mbe_pkg::PH_BH);
                n_drv = !n_reading && !n_shift[7];
            end
            i2c_mbe_pkg::PH_AL,
            i2c_mbe_pkg::PH_AH: begin
                n_scl = (n_phase == i2c_mbe_pkg::PH_AH);
                n_drv = n_reading ? !n_stop : !i_cfg.ack_check;
            end
            i2c_mbe_pkg::PH_P0:   begin n_scl = 1'b0; n_drv = 1'b1; end
            i2c_mbe_pkg::PH_P1:   begin n_scl = 1'b1; n_drv = 1'b1; end
            default:              begin n_scl = 1'b1; n_drv = 1'b0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2c_mbe_pkg::PH_IDLE;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_tick      <= 16'd0;
            r_wait      <= 5'd0;
            r_stop      <= 1'b0;
            r_rdres     <= 8'd0;
            r_reading   <= 1'b0;
            r_ackf      <= 1'b0;
            r_nackf     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase   <= n_phase;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_tick    <= n_tick;
                r_wait    <= n_wait;
                r_stop    <= n_stop;
                r_rdres   <= n_rdres;
                r_reading <= n_reading;
                r_ackf    <= n_ackf;
                r_nackf   <= n_nackf;
            end
            if (o_q_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_scl    <= n_scl;
            r_drv    <= n_drv;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_ack    <= n_ack;
            r_status <= n_status;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.scl           = r_scl;
    assign o_res.sda_drive_low = r_drv;
    assign o_res.busy_res      = r_busy;
    assign o_res.done_res      = r_done;
    assign o_res.ack_ok        = r_ack;
    assign o_res.rd_byte       = r_rdres;
    assign o_res.status        = r_status;

endmodule

`default_nettype wire

>>> hw/rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c master byte engine
// i2c master sequencing start, address, byte write/read, ack slot and stop,
// timed by tick requests that also carry the sampled sda level
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  i_req     in    valid/ready        req_type, dev_addr, read_dir, wr_byte,
//                                     last_byte, sda_in
//  o_res     out   valid/ready        scl, sda_drive_low, busy_res, done_res,
//                                     ack_ok, rd_byte, status
//  i_cfg_*   in    write enable only  i_cfg_idx, i_cfg_wdata
//
//  one request per cycle sustained while results are taken: each request is
//  one step of the phase sequencer in the back end, its result registered as
//  it leaves the queue, so it passes a queue entry and then the result register
//  a two-entry queue sits between front and back; a stalled result stops
//  the back end only, the front keeps taking requests until the queue fills
//  synchronous active-low reset returns to idle with state and config registers at defaults
//
`default_nettype none

module i2c_master_byte_engine (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    i2c_mbe_req_if.sink                            i_req,
    i2c_mbe_res_if.source                          o_res,
    input  wire                                    i_cfg_we,
    input  wire [i2c_mbe_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [i2c_mbe_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    `include "i2c_master_byte_engine_assert.svh"

    // configuration registers, read live by the back end
    i2c_mbe_pkg::t_cfg   r_cfg;
    i2c_mbe_pkg::t_q_out w_q;
    logic                w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= i2c_mbe_pkg::HALF_PERIOD_RST;
            r_cfg.ack_wait_limit    <= i2c_mbe_pkg::ACK_WAIT_RST;
            r_cfg.ack_check         <= i2c_mbe_pkg::ACK_CHECK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2c_mbe_pkg::CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_wdata;
                i2c_mbe_pkg::CFG_ACK_WAIT:    r_cfg.ack_wait_limit    <= i_cfg_wdata[4:0];
                i2c_mbe_pkg::CFG_ACK_CHECK:   r_cfg.ack_check         <= i_cfg_wdata[0];
                default:                      r_cfg <= r_cfg; // unmapped index ignored
            endcase
        end
    end

    // front: accept and classify requests into the queue
    i2c_mbe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_q     (w_q),
        .i_q_pop (w_q_pop)
    );

    // back: phase sequencer and result register
    i2c_mbe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_q     (w_q),
        .o_q_pop (w_q_pop),
        .o_res   (o_res)
    );

    // a pop only happens with something queued
    `MBE_ASSERT_IMPLIES(a_pop_needs_entry, i_clk, i_rst_n, w_q_pop, w_q.valid)

    // a finished command never reports a refusal
    `MBE_ASSERT_IMPLIES(a_done_not_refused, i_clk, i_rst_n, o_res.valid && o_res.done_res,
        o_res.status != i2c_mbe_pkg::ST_REFUSED)

    // no-ack status comes only with a done pulse and no ack
    `MBE_ASSERT_IMPLIES(a_nack_is_done, i_clk, i_rst_n,
        o_res.valid && o_res.status == i2c_mbe_pkg::ST_NACK,
        o_res.done_res && !o_res.ack_ok && !o_res.busy_res)

    // a popped request always leaves a result in the output register
    `MBE_ASSERT_NEXT(a_pop_gives_result, i_clk, i_rst_n, w_q_pop, o_res.valid)

endmodule

`default_nettype wire
